@@ rtl/core/qvr_pkg.sv @@
// ---------------------------------------------------------------------------
// qvr_pkg
// shared types and constants of the quaternion vector rotator
// ---------------------------------------------------------------------------
package qvr_pkg;

  localparam int QUAT_WIDTH    = 16;
  localparam int ROT_WIDTH     = 18;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int ROT_MAX       = 131071;
  localparam int ROT_MIN       = -131072;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_QUAT_W = 2'd0,
    CFG_QUAT_I = 2'd1,
    CFG_QUAT_J = 2'd2,
    CFG_QUAT_K = 2'd3
  } cfg_idx_e;

endpackage

@@ rtl/core/qvr_if.sv @@
// ---------------------------------------------------------------------------
// qvr interfaces
// valid/ready channels for input vectors and rotated result words
// ---------------------------------------------------------------------------
interface qvr_vec_if #(
  parameter int VEC_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] vec_x;
  logic signed [VEC_WIDTH-1:0] vec_y;
  logic signed [VEC_WIDTH-1:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface qvr_rot_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qvr_pkg::ROT_WIDTH-1:0]  rot_x;
  logic signed [qvr_pkg::ROT_WIDTH-1:0]  rot_y;
  logic signed [qvr_pkg::ROT_WIDTH-1:0]  rot_z;
  logic                                  clipped;

  modport source (output valid, output rot_x, output rot_y, output rot_z, output clipped,
                  input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z, input clipped,
                  output ready);
endinterface

@@ rtl/core/qvr_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// qvr_cfg_regs
// rotation quaternion registers, identity after reset
// ---------------------------------------------------------------------------
module qvr_cfg_regs #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int QW             = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [qvr_pkg::CFG_IDX_WIDTH-1:0]      cfg_idx_i,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]         cfg_data_i,
  output logic signed [QW-1:0]                   quat_w_o,
  output logic signed [QW-1:0]                   quat_i_o,
  output logic signed [QW-1:0]                   quat_j_o,
  output logic signed [QW-1:0]                   quat_k_o
);

  localparam logic signed [QW-1:0] ONE =
    {{(QW-QUAT_FRAC_BITS-1){1'b0}}, 1'b1, {QUAT_FRAC_BITS{1'b0}}};

  logic signed [QW-1:0] w_q, i_q, j_q, k_q;
  logic signed [QW-1:0] data_ext;

  assign data_ext = QW'($signed(cfg_data_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= ONE;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (cfg_we_i) begin
      case (qvr_pkg::cfg_idx_e'(cfg_idx_i))
        qvr_pkg::CFG_QUAT_W: w_q <= data_ext;
        qvr_pkg::CFG_QUAT_I: i_q <= data_ext;
        qvr_pkg::CFG_QUAT_J: j_q <= data_ext;
        qvr_pkg::CFG_QUAT_K: k_q <= data_ext;
        default: ;
      endcase
    end
  end

  assign quat_w_o = w_q;
  assign quat_i_o = i_q;
  assign quat_j_o = j_q;
  assign quat_k_o = k_q;

endmodule

@@ rtl/core/qvr_ham_left.sv @@
// ---------------------------------------------------------------------------
// qvr_ham_left
// first hamilton product q * (0,v): product stage, then sum stage
// ---------------------------------------------------------------------------
module qvr_ham_left #(
  parameter int QW        = 16,
  parameter int VEC_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [VEC_WIDTH-1:0]    vec_x_i,
  input  logic signed [VEC_WIDTH-1:0]    vec_y_i,
  input  logic signed [VEC_WIDTH-1:0]    vec_z_i,
  input  logic signed [QW-1:0]           quat_w_i,
  input  logic signed [QW-1:0]           quat_i_i,
  input  logic signed [QW-1:0]           quat_j_i,
  input  logic signed [QW-1:0]           quat_k_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [QW+VEC_WIDTH+1:0] p_w_o,
  output logic signed [QW+VEC_WIDTH+1:0] p_x_o,
  output logic signed [QW+VEC_WIDTH+1:0] p_y_o,
  output logic signed [QW+VEC_WIDTH+1:0] p_z_o
);

  localparam int MW = QW + VEC_WIDTH;
  localparam int PW = MW + 2;

  logic                 va_q, vb_q;
  logic                 en_a, en_b;
  logic signed [MW-1:0] m_d [12];
  logic signed [MW-1:0] m_q [12];
  logic signed [PW-1:0] pw_d, px_d, py_d, pz_d;
  logic signed [PW-1:0] pw_q, px_q, py_q, pz_q;

  assign en_b       = !vb_q || out_ready_i;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  // products of q and v, grouped by result component
  assign m_d[0]  = MW'(quat_i_i) * MW'(vec_x_i);
  assign m_d[1]  = MW'(quat_j_i) * MW'(vec_y_i);
  assign m_d[2]  = MW'(quat_k_i) * MW'(vec_z_i);
  assign m_d[3]  = MW'(quat_w_i) * MW'(vec_x_i);
  assign m_d[4]  = MW'(quat_j_i) * MW'(vec_z_i);
  assign m_d[5]  = MW'(quat_k_i) * MW'(vec_y_i);
  assign m_d[6]  = MW'(quat_w_i) * MW'(vec_y_i);
  assign m_d[7]  = MW'(quat_i_i) * MW'(vec_z_i);
  assign m_d[8]  = MW'(quat_k_i) * MW'(vec_x_i);
  assign m_d[9]  = MW'(quat_w_i) * MW'(vec_z_i);
  assign m_d[10] = MW'(quat_i_i) * MW'(vec_y_i);
  assign m_d[11] = MW'(quat_j_i) * MW'(vec_x_i);

  assign pw_d = -PW'(m_q[0]) - PW'(m_q[1]) - PW'(m_q[2]);
  assign px_d =  PW'(m_q[3]) + PW'(m_q[4]) - PW'(m_q[5]);
  assign py_d =  PW'(m_q[6]) - PW'(m_q[7]) + PW'(m_q[8]);
  assign pz_d =  PW'(m_q[9]) + PW'(m_q[10]) - PW'(m_q[11]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= in_valid_i;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      m_q <= m_d;
    end
    if (en_b) begin
      pw_q <= pw_d;
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
    end
  end

  assign out_valid_o = vb_q;
  assign p_w_o       = pw_q;
  assign p_x_o       = px_q;
  assign p_y_o       = py_q;
  assign p_z_o       = pz_q;

endmodule

@@ rtl/core/qvr_ham_right.sv @@
// ---------------------------------------------------------------------------
// qvr_ham_right
// vector part of p * conj(q): product stage, then sum stage
// ---------------------------------------------------------------------------
module qvr_ham_right #(
  parameter int QW        = 16,
  parameter int VEC_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [QW+VEC_WIDTH+1:0]      p_w_i,
  input  logic signed [QW+VEC_WIDTH+1:0]      p_x_i,
  input  logic signed [QW+VEC_WIDTH+1:0]      p_y_i,
  input  logic signed [QW+VEC_WIDTH+1:0]      p_z_i,
  input  logic signed [QW-1:0]                quat_w_i,
  input  logic signed [QW-1:0]                quat_i_i,
  input  logic signed [QW-1:0]                quat_j_i,
  input  logic signed [QW-1:0]                quat_k_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [2*QW+VEC_WIDTH+4:0]    acc_x_o,
  output logic signed [2*QW+VEC_WIDTH+4:0]    acc_y_o,
  output logic signed [2*QW+VEC_WIDTH+4:0]    acc_z_o
);

  localparam int PW = QW + VEC_WIDTH + 2;
  localparam int NW = PW + QW;
  localparam int AW = 2*QW + VEC_WIDTH + 5;

  logic                 va_q, vb_q;
  logic                 en_a, en_b;
  logic signed [NW-1:0] n_d [12];
  logic signed [NW-1:0] n_q [12];
  logic signed [AW-1:0] ax_d, ay_d, az_d;
  logic signed [AW-1:0] ax_q, ay_q, az_q;

  assign en_b       = !vb_q || out_ready_i;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  assign n_d[0]  = NW'(p_w_i) * NW'(quat_i_i);
  assign n_d[1]  = NW'(p_x_i) * NW'(quat_w_i);
  assign n_d[2]  = NW'(p_y_i) * NW'(quat_k_i);
  assign n_d[3]  = NW'(p_z_i) * NW'(quat_j_i);
  assign n_d[4]  = NW'(p_w_i) * NW'(quat_j_i);
  assign n_d[5]  = NW'(p_x_i) * NW'(quat_k_i);
  assign n_d[6]  = NW'(p_y_i) * NW'(quat_w_i);
  assign n_d[7]  = NW'(p_z_i) * NW'(quat_i_i);
  assign n_d[8]  = NW'(p_w_i) * NW'(quat_k_i);
  assign n_d[9]  = NW'(p_x_i) * NW'(quat_j_i);
  assign n_d[10] = NW'(p_y_i) * NW'(quat_i_i);
  assign n_d[11] = NW'(p_z_i) * NW'(quat_w_i);

  // conj(q) negates the imaginary parts
  assign ax_d = -AW'(n_q[0]) + AW'(n_q[1]) - AW'(n_q[2])  + AW'(n_q[3]);
  assign ay_d = -AW'(n_q[4]) + AW'(n_q[5]) + AW'(n_q[6])  - AW'(n_q[7]);
  assign az_d = -AW'(n_q[8]) - AW'(n_q[9]) + AW'(n_q[10]) + AW'(n_q[11]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= in_valid_i;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      n_q <= n_d;
    end
    if (en_b) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      az_q <= az_d;
    end
  end

  assign out_valid_o = vb_q;
  assign acc_x_o     = ax_q;
  assign acc_y_o     = ay_q;
  assign acc_z_o     = az_q;

endmodule

@@ rtl/core/qvr_round_sat.sv @@
// ---------------------------------------------------------------------------
// qvr_round_sat
// round to nearest, scale back, saturate; holds the output word
// ---------------------------------------------------------------------------
module qvr_round_sat #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int QW             = 16,
  parameter int VEC_WIDTH      = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [2*QW+VEC_WIDTH+4:0]       acc_x_i,
  input  logic signed [2*QW+VEC_WIDTH+4:0]       acc_y_i,
  input  logic signed [2*QW+VEC_WIDTH+4:0]       acc_z_i,
  qvr_rot_if.source                              rot_o
);

  localparam int AW    = 2*QW + VEC_WIDTH + 5;
  localparam int SHIFT = 2*QUAT_FRAC_BITS;
  localparam int RW    = AW - SHIFT;
  localparam int XW    = (RW > qvr_pkg::ROT_WIDTH) ? RW : qvr_pkg::ROT_WIDTH + 1;
  localparam logic signed [AW-1:0] HALF =
    {{(AW-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};

  function automatic logic [qvr_pkg::ROT_WIDTH:0] sat_f(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] rn;
    logic signed [XW-1:0] r;
    logic [qvr_pkg::ROT_WIDTH:0] res;
    rn = a + HALF;
    r  = XW'($signed(rn[AW-1:SHIFT]));
    if (r > XW'(qvr_pkg::ROT_MAX)) begin
      res = {1'b1, qvr_pkg::ROT_WIDTH'(qvr_pkg::ROT_MAX)};
    end else if (r < XW'(qvr_pkg::ROT_MIN)) begin
      res = {1'b1, qvr_pkg::ROT_WIDTH'(qvr_pkg::ROT_MIN)};
    end else begin
      res = {1'b0, r[qvr_pkg::ROT_WIDTH-1:0]};
    end
    return res;
  endfunction

  logic                            v_q;
  logic                            en;
  logic [qvr_pkg::ROT_WIDTH:0]     sx, sy, sz;
  logic [qvr_pkg::ROT_WIDTH-1:0]   rx_q, ry_q, rz_q;
  logic                            clip_q;

  assign en         = !v_q || rot_o.ready;
  assign in_ready_o = en;

  assign sx = sat_f(acc_x_i);
  assign sy = sat_f(acc_y_i);
  assign sz = sat_f(acc_z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q   <= sx[qvr_pkg::ROT_WIDTH-1:0];
      ry_q   <= sy[qvr_pkg::ROT_WIDTH-1:0];
      rz_q   <= sz[qvr_pkg::ROT_WIDTH-1:0];
      clip_q <= sx[qvr_pkg::ROT_WIDTH] | sy[qvr_pkg::ROT_WIDTH] | sz[qvr_pkg::ROT_WIDTH];
    end
  end

  assign rot_o.valid   = v_q;
  assign rot_o.rot_x   = $signed(rx_q);
  assign rot_o.rot_y   = $signed(ry_q);
  assign rot_o.rot_z   = $signed(rz_q);
  assign rot_o.clipped = clip_q;

endmodule

@@ rtl/core/quaternion_vector_rotate.sv @@
// ---------------------------------------------------------------------------
// quaternion_vector_rotate
// rotates each vector word by the configured quaternion
// ---------------------------------------------------------------------------
// Takes one vector word per clock and returns one rotated word per clock
// while the output side is not stalled. The five register stages are: q*v
// products, sums of the first hamilton product, p*q products, sums of the
// second product, and rounding with saturation into the output register.
// The two multiplier banks set the stage depth. A stall on the output
// freezes only the stages that are full, so bubbles collapse.
// Write the quaternion (Q2.14, identity after reset) only while the pipeline
// is empty; it is not normalized, so a non-unit quaternion scales the result.
module quaternion_vector_rotate #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int VEC_WIDTH      = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  qvr_vec_if.sink                             vec_i,
  qvr_rot_if.source                           rot_o,
  input  logic                                cfg_we_i,
  input  logic [qvr_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]      cfg_data_i
);

  localparam int QW = (QUAT_FRAC_BITS + 2 > qvr_pkg::QUAT_WIDTH) ?
                      QUAT_FRAC_BITS + 2 : qvr_pkg::QUAT_WIDTH;
  localparam int PW = QW + VEC_WIDTH + 2;
  localparam int AW = 2*QW + VEC_WIDTH + 5;

  logic signed [QW-1:0] quat_w, quat_i, quat_j, quat_k;
  logic                 l_valid, l_ready;
  logic signed [PW-1:0] p_w, p_x, p_y, p_z;
  logic                 r_valid, r_ready;
  logic signed [AW-1:0] acc_x, acc_y, acc_z;

  qvr_cfg_regs #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .QW             (QW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .quat_w_o   (quat_w),
    .quat_i_o   (quat_i),
    .quat_j_o   (quat_j),
    .quat_k_o   (quat_k)
  );

  qvr_ham_left #(
    .QW        (QW),
    .VEC_WIDTH (VEC_WIDTH)
  ) u_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vec_i.valid),
    .in_ready_o  (vec_i.ready),
    .vec_x_i     (vec_i.vec_x),
    .vec_y_i     (vec_i.vec_y),
    .vec_z_i     (vec_i.vec_z),
    .quat_w_i    (quat_w),
    .quat_i_i    (quat_i),
    .quat_j_i    (quat_j),
    .quat_k_i    (quat_k),
    .out_valid_o (l_valid),
    .out_ready_i (l_ready),
    .p_w_o       (p_w),
    .p_x_o       (p_x),
    .p_y_o       (p_y),
    .p_z_o       (p_z)
  );

  qvr_ham_right #(
    .QW        (QW),
    .VEC_WIDTH (VEC_WIDTH)
  ) u_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (l_valid),
    .in_ready_o  (l_ready),
    .p_w_i       (p_w),
    .p_x_i       (p_x),
    .p_y_i       (p_y),
    .p_z_i       (p_z),
    .quat_w_i    (quat_w),
    .quat_i_i    (quat_i),
    .quat_j_i    (quat_j),
    .quat_k_i    (quat_k),
    .out_valid_o (r_valid),
    .out_ready_i (r_ready),
    .acc_x_o     (acc_x),
    .acc_y_o     (acc_y),
    .acc_z_o     (acc_z)
  );

  qvr_round_sat #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .QW             (QW),
    .VEC_WIDTH      (VEC_WIDTH)
  ) u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (r_valid),
    .in_ready_o (r_ready),
    .acc_x_i    (acc_x),
    .acc_y_i    (acc_y),
    .acc_z_i    (acc_z),
    .rot_o      (rot_o)
  );

endmodule

@@ rtl/core/qvr_checker.sv @@
// ---------------------------------------------------------------------------
// qvr_checker
// port-level checks of the rotator, bound to the top level
// ---------------------------------------------------------------------------
module qvr_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [qvr_pkg::ROT_WIDTH-1:0] rot_x_i,
  input logic signed [qvr_pkg::ROT_WIDTH-1:0] rot_y_i,
  input logic signed [qvr_pkg::ROT_WIDTH-1:0] rot_z_i,
  input logic                                 clipped_i
);

  localparam int DEPTH = 5;

  logic       in_acc, out_acc;
  logic [3:0] pend_q, pend_d;
  logic       x_edge, y_edge, z_edge;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign pend_d  = pend_q + 4'(in_acc) - 4'(out_acc);

  assign x_edge = (rot_x_i == qvr_pkg::ROT_WIDTH'(qvr_pkg::ROT_MAX)) ||
                  (rot_x_i == qvr_pkg::ROT_WIDTH'(qvr_pkg::ROT_MIN));
  assign y_edge = (rot_y_i == qvr_pkg::ROT_WIDTH'(qvr_pkg::ROT_MAX)) ||
                  (rot_y_i == qvr_pkg::ROT_WIDTH'(qvr_pkg::ROT_MIN));
  assign z_edge = (rot_z_i == qvr_pkg::ROT_WIDTH'(qvr_pkg::ROT_MAX)) ||
                  (rot_z_i == qvr_pkg::ROT_WIDTH'(qvr_pkg::ROT_MIN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rot_x_i) && $stable(rot_y_i)
      && $stable(rot_z_i) && $stable(clipped_i))
    else $error("result word changed while stalled");

  // no word leaves without one having entered
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 4'd0)
    else $error("result word without a pending input word");

  // never more words in flight than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'(DEPTH))
    else $error("more words in flight than stages");

  // clip flag only with a component at a rail
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clipped_i |-> x_edge || y_edge || z_edge)
    else $error("clipped set with no saturated component");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (vec_i.valid),
  .in_ready_i  (vec_i.ready),
  .out_valid_i (rot_o.valid),
  .out_ready_i (rot_o.ready),
  .rot_x_i     (rot_o.rot_x),
  .rot_y_i     (rot_o.rot_y),
  .rot_z_i     (rot_o.rot_z),
  .clipped_i   (rot_o.clipped)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the quaternion vector rotator
// ---------------------------------------------------------------------------
// A short table of directed words runs first. It covers identity after reset,
// rounding ties, quaternion extremes and a half turn about x, each against
// hand-worked values or the bench's exact integer rotation. Random phases
// follow. Each phase loads a fresh quaternion and streams random vectors,
// with the sender idling and the receiver stalling in turns, plus one long
// receiver hold-off that backs the pipeline up to its input.
// ---------------------------------------------------------------------------
module tb;

  localparam int FRAC_BITS   = 14;
  localparam int VEC_W       = 16;
  localparam int ROUND_SHIFT = 2 * FRAC_BITS;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 50;

  typedef struct packed {
    logic signed [qvr_pkg::ROT_WIDTH-1:0] x;
    logic signed [qvr_pkg::ROT_WIDTH-1:0] y;
    logic signed [qvr_pkg::ROT_WIDTH-1:0] z;
    logic                                 clipped;
  } rot_word_t;

  typedef enum logic [0:0] {ROW_QUAT, ROW_VEC} row_kind_e;

  // quat rows carry w, i, j, k in a..d; vector rows carry x, y, z in a..c
  typedef struct packed {
    row_kind_e                            kind;
    logic signed [15:0]                   a;
    logic signed [15:0]                   b;
    logic signed [15:0]                   c;
    logic signed [15:0]                   d;
    logic                                 typed;
    logic signed [qvr_pkg::ROT_WIDTH-1:0] ex;
    logic signed [qvr_pkg::ROT_WIDTH-1:0] ey;
    logic signed [qvr_pkg::ROT_WIDTH-1:0] ez;
    logic                                 eclip;
  } dir_row_t;

  localparam int NUM_DIR = 27;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_VEC,       0,      0,      0, 0, 1'b1,      0,       0,      0, 1'b0},
    '{ROW_VEC,   32767, -32768,      1, 0, 1'b1,  32767,  -32768,      1, 1'b0},
    '{ROW_VEC,  -32768,  32767,     -1, 0, 1'b1, -32768,   32767,     -1, 1'b0},
    '{ROW_VEC,      -1,     -1,     -1, 0, 1'b1,     -1,      -1,     -1, 1'b0},
    '{ROW_VEC,   12345,  -2222,    777, 0, 1'b1,  12345,   -2222,    777, 1'b0},
    '{ROW_QUAT,   8192,      0,      0, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_VEC,       2,     -2,     -6, 0, 1'b1,      1,       0,     -1, 1'b0},
    '{ROW_VEC,       1,     -1,      3, 0, 1'b1,      0,       0,      1, 1'b0},
    '{ROW_VEC,   32767, -32768,      5, 0, 1'b1,   8192,   -8192,      1, 1'b0},
    '{ROW_QUAT, -32768,      0,      0, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_VEC,   32767, -32768,      0, 0, 1'b1, 131068, -131072,      0, 1'b0},
    '{ROW_QUAT,      0,  16384,      0, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_VEC,     100,   -200,   -300, 0, 1'b1,    100,     200,    300, 1'b0},
    '{ROW_VEC,  -32768, -32768, -32768, 0, 1'b1, -32768,   32768,  32768, 1'b0},
    '{ROW_QUAT, -32768, -32768,  32767, -32768, 1'b0, 0,       0,      0, 1'b0},
    '{ROW_VEC,   32767,  32767,  32767, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_VEC,  -32768, -32768, -32768, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_VEC,   32767, -32768,      0, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_VEC,       0,      0,      1, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_QUAT,  11585,      0,      0, 11585, 1'b0,  0,       0,      0, 1'b0},
    '{ROW_VEC,    1000,      0,      0, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_VEC,       0,   1000,      0, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_VEC,       0,      0,   1000, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_QUAT,  32767,  32767,  32767, 32767, 1'b0,  0,       0,      0, 1'b0},
    '{ROW_VEC,   32767, -32768,  32767, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_QUAT,      0,      0,      0, 0, 1'b0,      0,       0,      0, 1'b0},
    '{ROW_VEC,   32767,  32767, -32768, 0, 1'b1,      0,       0,      0, 1'b0}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  qvr_pkg::cfg_idx_e              cfg_idx_i;
  logic [qvr_pkg::QUAT_WIDTH-1:0] cfg_data_i;

  qvr_vec_if #(.VEC_WIDTH(VEC_W)) vec_if ();
  qvr_rot_if                      rot_if ();

  quaternion_vector_rotate #(
    .QUAT_FRAC_BITS(FRAC_BITS),
    .VEC_WIDTH     (VEC_W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vec_i     (vec_if.sink),
    .rot_o     (rot_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [qvr_pkg::QUAT_WIDTH-1:0] q_w, q_i, q_j, q_k;
  rot_word_t rot_pending[$];
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int err_cnt = 0;
  int got_cnt = 0;
  int clip_cnt = 0;
  int quat_cnt = 0;

  function automatic logic signed [qvr_pkg::ROT_WIDTH-1:0] round_sat(input longint acc,
                                                                     inout logic clip);
    longint r;
    r = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (r > qvr_pkg::ROT_MAX) begin
      clip = 1'b1;
      r = qvr_pkg::ROT_MAX;
    end else if (r < qvr_pkg::ROT_MIN) begin
      clip = 1'b1;
      r = qvr_pkg::ROT_MIN;
    end
    return r[qvr_pkg::ROT_WIDTH-1:0];
  endfunction

  // exact q * (0,v) * conj(q), then round and saturate each component
  function automatic rot_word_t rotate_vec(input logic signed [VEC_W-1:0] vx, vy, vz);
    longint w, i, j, k, x, y, z, pw, px, py, pz;
    logic clip;
    rot_word_t r;
    w = q_w; i = q_i; j = q_j; k = q_k;
    x = vx; y = vy; z = vz;
    pw = -i * x - j * y - k * z;
    px =  w * x + j * z - k * y;
    py =  w * y - i * z + k * x;
    pz =  w * z + i * y - j * x;
    clip = 1'b0;
    r.x = round_sat(-pw * i + px * w - py * k + pz * j, clip);
    r.y = round_sat(-pw * j + px * k + py * w - pz * i, clip);
    r.z = round_sat(-pw * k - px * j + py * i + pz * w, clip);
    r.clipped = clip;
    return r;
  endfunction

  function automatic logic signed [VEC_W-1:0] rand_comp();
    if ($urandom_range(9) < 2) begin
      case ($urandom_range(4))
        0:       return VEC_W'(-32768);
        1:       return VEC_W'(32767);
        2:       return VEC_W'(0);
        3:       return VEC_W'(-1);
        default: return VEC_W'(1);
      endcase
    end
    return VEC_W'($urandom);
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic load_quat(input logic signed [qvr_pkg::QUAT_WIDTH-1:0] w, i, j, k);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= qvr_pkg::CFG_QUAT_W;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= qvr_pkg::CFG_QUAT_I;
    cfg_data_i <= i;
    @(posedge clk_i);
    cfg_idx_i  <= qvr_pkg::CFG_QUAT_J;
    cfg_data_i <= j;
    @(posedge clk_i);
    cfg_idx_i  <= qvr_pkg::CFG_QUAT_K;
    cfg_data_i <= k;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    q_w = w; q_i = i; q_j = j; q_k = k;
    quat_cnt++;
  endtask

  task automatic offer_vec(input logic signed [VEC_W-1:0] x, y, z, input rot_word_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      vec_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    vec_if.valid <= 1'b1;
    vec_if.vec_x <= x;
    vec_if.vec_y <= y;
    vec_if.vec_z <= z;
    @(posedge clk_i);
    while (!vec_if.ready) @(posedge clk_i);
    rot_pending.push_back(want);
  endtask

  task automatic wait_drain();
    vec_if.valid <= 1'b0;
    while (rot_pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // result side
  initial begin
    rot_word_t want;
    rot_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rot_if.valid && rot_if.ready) begin
        if (rot_pending.size() == 0) begin
          $error("rotated word with no vector pending");
          err_cnt++;
        end else begin
          want = rot_pending.pop_front();
          check_field("rot_x", want.x, rot_if.rot_x);
          check_field("rot_y", want.y, rot_if.rot_y);
          check_field("rot_z", want.z, rot_if.rot_z);
          check_field("clipped", want.clipped, rot_if.clipped);
          got_cnt++;
          if (want.clipped) clip_cnt++;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rot_if.ready <= 1'b0;
      end else begin
        rot_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    dir_row_t  row;
    rot_word_t want;
    logic signed [VEC_W-1:0] x, y, z;
    rst_ni       = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= qvr_pkg::CFG_QUAT_W;
    cfg_data_i   <= '0;
    vec_if.valid <= 1'b0;
    vec_if.vec_x <= '0;
    vec_if.vec_y <= '0;
    vec_if.vec_z <= '0;
    q_w = 16'sd16384; q_i = '0; q_j = '0; q_k = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NUM_DIR; n++) begin
      row = DIR_ROWS[n];
      if (row.kind == ROW_QUAT) begin
        wait_drain();
        load_quat(row.a, row.b, row.c, row.d);
      end else begin
        if (row.typed) want = '{row.ex, row.ey, row.ez, row.eclip};
        else           want = rotate_vec(row.a, row.b, row.c);
        offer_vec(row.a, row.b, row.c, want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      case (ph % 3)
        0: load_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        1: load_quat(16'($urandom_range(23170) - 11585), 16'($urandom_range(23170) - 11585),
                     16'($urandom_range(23170) - 11585), 16'($urandom_range(23170) - 11585));
        default: load_quat(16'($urandom_range(1) ? 16384 : -32768),
                           16'($urandom_range(1) ? 0 : 32767),
                           16'($urandom_range(1) ? 0 : -32768),
                           16'($urandom_range(1) ? 16384 : 0));
      endcase
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      // long hold-off so the pipeline backs up and drops its input ready
      if (ph == 0) rx_hold = 60;
      repeat (PHASE_WORDS) begin
        x = rand_comp();
        y = rand_comp();
        z = rand_comp();
        offer_vec(x, y, z, rotate_vec(x, y, z));
      end
    end
    wait_drain();

    $display("checked %0d rotated words under %0d quaternion settings, %0d saturated",
             got_cnt, quat_cnt, clip_cnt);
    if (err_cnt == 0 && rot_pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
